### hw/rtl/gmpe_pkg.sv
`timescale 1ns / 1ps

package gmpe_pkg;

   // Block dimensions
   localparam int MAX_COLUMNS = 16;
   localparam int MAX_DATA    = 16;
   localparam int SYMBOL_BITS = 8;
   localparam int SELECT_BITS = 16;

   localparam int COL_IDX_W  = $clog2(MAX_COLUMNS);
   localparam int DATA_IDX_W = $clog2(MAX_DATA);

   // Field widths of the channels
   localparam int COLUMN_W     = 4;
   localparam int SLOT_W       = 4;
   localparam int VALUE_W      = 8;
   localparam int OUT_COLUMN_W = 4;
   localparam int SYMBOL_W     = 8;

   // Configuration registers
   localparam int DATA_COUNT_W = 5;
   localparam int SELECT_W     = 16;
   localparam int POLY_W       = 9;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_SELECT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_POLY    = 2'd2;

   localparam logic [DATA_COUNT_W-1:0] DATA_COUNT_RESET = 5'd1;
   localparam logic [SELECT_W-1:0]     SELECT_RESET     = 16'd0;
   localparam logic [POLY_W-1:0]       POLY_RESET       = 9'd285;

   // Operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DATA = 1'b1;

   typedef logic [SYMBOL_BITS-1:0] sym_type;
   typedef sym_type [MAX_COLUMNS-1:0] sym_row_type;

   typedef struct packed {
      logic [DATA_COUNT_W-1:0] data_count;
      logic [SELECT_W-1:0]     column_select;
      logic [POLY_W-1:0]       field_polynomial;
   } cfg_type;

   // Accumulator snapshot handed from the datapath to the emitter
   typedef struct packed {
      logic                   valid;
      logic [MAX_COLUMNS-1:0] mask;
      sym_row_type            symbols;
   } snap_type;

   // Carry-less product reduced by the low bits of the field polynomial
   function automatic sym_type gf_mul(input sym_type a, input sym_type b,
                                      input sym_type low);
      sym_type r;
      sym_type aa;
      logic    top;
      r  = '0;
      aa = a;
      for (int i = 0; i < SYMBOL_BITS; i++) begin
         if (b[i]) begin
            r = r ^ aa;
         end
         top = aa[SYMBOL_BITS-1];
         aa  = aa << 1;
         if (top) begin
            aa = aa ^ low;
         end
      end
      return r;
   endfunction

   // Enabled output columns; select bits past the column count are ignored
   function automatic logic [MAX_COLUMNS-1:0] column_mask(input logic [SELECT_W-1:0] sel);
      logic [MAX_COLUMNS-1:0] m;
      m = '0;
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         if (c < SELECT_BITS) begin
            m[c] = sel[c];
         end
      end
      return m;
   endfunction

endpackage

### hw/rtl/gmpe_ifs.sv
`timescale 1ns / 1ps

interface gmpe_req_if;
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic [gmpe_pkg::COLUMN_W-1:0] column;
   logic [gmpe_pkg::SLOT_W-1:0]   coef_slot;
   logic [gmpe_pkg::VALUE_W-1:0]  value;
   logic                          last;

   modport source (output valid, operation, column, coef_slot, value, last, input ready);
   modport sink   (input valid, operation, column, coef_slot, value, last, output ready);
endinterface

interface gmpe_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [gmpe_pkg::OUT_COLUMN_W-1:0] out_column;
   logic [gmpe_pkg::SYMBOL_W-1:0]     symbol;
   logic                              out_last;

   modport source (output valid, out_column, symbol, out_last, input ready);
   modport sink   (input valid, out_column, symbol, out_last, output ready);
endinterface

interface gmpe_csr_if;
   logic                             valid;
   logic                             ready;
   logic [gmpe_pkg::CSR_INDEX_W-1:0] index;
   logic [gmpe_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/gf256_matrix_parity_encoder.sv
`timescale 1ns / 1ps

// GF(2^8) matrix parity encoder. Load transactions (operation 0) write one
// coefficient, addressed by output column and data column (coef_slot), into a
// 16-row table held in a single memory, one row per data column; the table
// has no reset and must be loaded before use. Data transactions (operation 1)
// read the row of their data column and, in the same pass, XOR the field
// product coefficient * value into the accumulator of every column enabled
// in column_select, all 16 columns in parallel. A data transaction with last
// set ends the position: the accumulators are copied into the emitter and
// cleared, and the emitter hands out one result transaction per enabled
// column in ascending column order, one per cycle while the receiver is ready,
// with out_last on the final one. Rate: one input transaction per cycle for
// loads and data unless a last data transaction is held, with two stages
// (memory read into the execute register, then accumulate). A position's
// first symbol passes the execute, snapshot and result registers. A following
// last data transaction waits in the execute stage, holding off the input,
// until the emitter has handed out every symbol of the previous position.
// The result register decouples the sides, so input keeps flowing while a
// symbol waits to be taken. Configuration registers (index 0 data_count,
// 1 column_select, 2 field_polynomial) are written through the csr channel,
// which is always ready; write them only while the block is idle.

module gf256_matrix_parity_encoder (
   input logic       clock,
   input logic       reset,
   gmpe_req_if.sink  req_bus,
   gmpe_rsp_if.source rsp_bus,
   gmpe_csr_if.sink  csr_bus
);
   import gmpe_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   snap_type snap;
   logic     dp_ready, accept, csr_fire, emit_idle;

   // Configuration writes are always accepted
   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_fire) begin
         case (csr_bus.index)
            CSR_DATA_COUNT: begin
               cfg_in.data_count = csr_bus.data[DATA_COUNT_W-1:0];
            end
            CSR_COLUMN_SELECT: begin
               cfg_in.column_select = csr_bus.data[SELECT_W-1:0];
            end
            CSR_FIELD_POLY: begin
               cfg_in.field_polynomial = csr_bus.data[POLY_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;  // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_count       <= DATA_COUNT_RESET;
         cfg_ff.column_select    <= SELECT_RESET;
         cfg_ff.field_polynomial <= POLY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input side: hold off only when the execute stage cannot advance
   assign req_bus.ready = dp_ready;
   assign accept        = req_bus.valid && dp_ready;

   gmpe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_bus.operation),
      .column    (req_bus.column),
      .coef_slot (req_bus.coef_slot),
      .value     (req_bus.value),
      .last      (req_bus.last),
      .cfg       (cfg_ff),
      .emit_idle (emit_idle),
      .in_ready  (dp_ready),
      .snap      (snap)
   );

   // Output side: drain the snapshot one column per cycle while the receiver is ready
   gmpe_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .snap           (snap),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_out_column (rsp_bus.out_column),
      .rsp_symbol     (rsp_bus.symbol),
      .rsp_out_last   (rsp_bus.out_last),
      .idle           (emit_idle)
   );

endmodule

### hw/rtl/gmpe_datapath.sv
`timescale 1ns / 1ps

module gmpe_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          operation,
   input  logic [gmpe_pkg::COLUMN_W-1:0] column,
   input  logic [gmpe_pkg::SLOT_W-1:0]   coef_slot,
   input  logic [gmpe_pkg::VALUE_W-1:0]  value,
   input  logic                          last,
   input  gmpe_pkg::cfg_type             cfg,
   input  logic                          emit_idle,
   output logic                          in_ready,
   output gmpe_pkg::snap_type            snap
);
   import gmpe_pkg::*;

   // One row per data column, one symbol per output column
   sym_row_type coef_mem [MAX_DATA];

   logic                s1_valid_ff, s1_valid_in;
   logic [COLUMN_W-1:0] s1_column_ff;
   sym_type             s1_value_ff;
   logic                s1_last_ff;
   sym_row_type         coef_row_ff;
   sym_row_type         acc_ff, acc_in;

   logic                   load_hit, data_hit, s1_go, contrib;
   logic [MAX_COLUMNS-1:0] col_en;
   sym_row_type            acc_sum;

   assign load_hit = accept && (operation == OP_LOAD) &&
                     (int'(column) < MAX_COLUMNS) && (int'(coef_slot) < MAX_DATA);
   assign data_hit = accept && (operation == OP_DATA);

   // A last item waits until the emitter has drained the previous position
   assign s1_go    = s1_valid_ff && (!s1_last_ff || emit_idle);
   assign in_ready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (load_hit) begin
         coef_mem[DATA_IDX_W'(coef_slot)][COL_IDX_W'(column)] <= value[SYMBOL_BITS-1:0];
      end
      if (data_hit) begin
         coef_row_ff  <= coef_mem[DATA_IDX_W'(column)];
         s1_column_ff <= column;
         s1_value_ff  <= value[SYMBOL_BITS-1:0];
         s1_last_ff   <= last;
      end
   end

   assign contrib = (DATA_COUNT_W'(s1_column_ff) < cfg.data_count) &&
                    (int'(s1_column_ff) < MAX_DATA);
   assign col_en  = column_mask(cfg.column_select);

   always_comb begin
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         acc_sum[c] = acc_ff[c];
         if (contrib && col_en[c]) begin
            acc_sum[c] = acc_ff[c] ^ gf_mul(coef_row_ff[c], s1_value_ff,
                                            cfg.field_polynomial[SYMBOL_BITS-1:0]);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      acc_in      = acc_ff;
      if (s1_go) begin
         s1_valid_in = 1'b0;
         acc_in      = s1_last_ff ? '0 : acc_sum;
      end
      if (data_hit) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         acc_ff      <= acc_in;
      end
   end

   assign snap.valid   = s1_go && s1_last_ff;
   assign snap.mask    = col_en;
   assign snap.symbols = acc_sum;

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff && !emit_idle) |=> s1_valid_ff)
      else $error("stalled last item dropped from execute stage");

   assert property (@(posedge clock) disable iff (reset)
      snap.valid |=> (acc_ff == '0))
      else $error("accumulators not cleared after position end");

   assert property (@(posedge clock) disable iff (reset)
      snap.valid |-> emit_idle)
      else $error("snapshot handed over while emitter busy");

endmodule

### hw/rtl/gmpe_emit.sv
`timescale 1ns / 1ps

module gmpe_emit (
   input  logic                              clock,
   input  logic                              reset,
   input  gmpe_pkg::snap_type                snap,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [gmpe_pkg::OUT_COLUMN_W-1:0] rsp_out_column,
   output logic [gmpe_pkg::SYMBOL_W-1:0]     rsp_symbol,
   output logic                              rsp_out_last,
   output logic                              idle
);
   import gmpe_pkg::*;

   logic [MAX_COLUMNS-1:0]  pending_ff, pending_in;
   sym_row_type             sym_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_COLUMN_W-1:0] out_column_ff;
   logic [SYMBOL_W-1:0]     symbol_ff;
   logic                    out_last_ff;

   logic [MAX_COLUMNS-1:0] pick_oh;
   logic [COL_IDX_W-1:0]   pick_idx;
   logic                   out_free, drain, pick_last;

   // Lowest pending column goes out first
   assign pick_oh = pending_ff & (~pending_ff + MAX_COLUMNS'(1));

   always_comb begin
      pick_idx = '0;
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         if (pick_oh[c]) begin
            pick_idx = pick_idx | COL_IDX_W'(c);
         end
      end
   end

   assign pick_last = ((pending_ff & ~pick_oh) == '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign drain     = out_free && (pending_ff != '0);
   assign idle      = (pending_ff == '0);

   always_comb begin
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff;
      if (snap.valid) begin
         pending_in = snap.mask;
      end else if (drain) begin
         pending_in = pending_ff & ~pick_oh;
      end
      if (out_free) begin
         rsp_valid_in = drain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap.valid) begin
         sym_ff <= snap.symbols;
      end
      if (drain) begin
         out_column_ff <= OUT_COLUMN_W'(pick_idx);
         symbol_ff     <= SYMBOL_W'(sym_ff[pick_idx]);
         out_last_ff   <= pick_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_column = out_column_ff;
   assign rsp_symbol     = symbol_ff;
   assign rsp_out_last   = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      snap.valid |-> (pending_ff == '0))
      else $error("snapshot arrived while symbols still pending");

   assert property (@(posedge clock) disable iff (reset)
      (pending_ff != '0) |-> $onehot(pick_oh))
      else $error("column pick is not one-hot");

   assert property (@(posedge clock) disable iff (reset)
      (drain && pick_last) |=> (pending_ff == '0))
      else $error("pending columns left after final symbol");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import gmpe_pkg::*;

   // One input transaction as queued for the driver
   typedef struct {
      logic                operation;
      logic [COLUMN_W-1:0] column;
      logic [SLOT_W-1:0]   coef_slot;
      logic [VALUE_W-1:0]  value;
      logic                last;
      bit                  drain_first;   // hold until every symbol in flight is out
   } req_item_type;

   // One code symbol as it should leave the block
   typedef struct {
      logic [OUT_COLUMN_W-1:0] out_column;
      logic [SYMBOL_W-1:0]     symbol;
      logic                    out_last;
   } symbol_type;

   typedef enum int {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_mode_type;

   localparam int LONG_HOLD_CYCLES = 160;
   localparam int SETTLE_CYCLES    = 8;
   localparam int MAX_REPORTS      = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gmpe_req_if req_bus ();
   gmpe_rsp_if rsp_bus ();
   gmpe_csr_if csr_bus ();

   gf256_matrix_parity_encoder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow copy of the encoder: coefficient table, accumulators, registers
   logic [SYMBOL_W-1:0]     coef_tab [MAX_COLUMNS][MAX_DATA];
   logic [SYMBOL_W-1:0]     parity_acc [MAX_COLUMNS];
   logic [DATA_COUNT_W-1:0] shadow_count;
   logic [SELECT_W-1:0]     shadow_select;
   logic [POLY_W-1:0]       shadow_poly;

   symbol_type    pending_symbols [$];   // symbols owed by the block, oldest first
   req_item_type  stim_q [$];            // transactions waiting for the driver
   flow_mode_type flow_mode  = FLOW_FREE;
   int            fail_count = 0;
   int            hold_go    = 0;        // bump to request one long receiver hold-off
   int            hold_seen  = 0;
   int            stall_left = 0;
   bit            req_taken  = 1'b0;     // input transaction accepted at the last rising edge

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // GF(2^8) product, Horner style: shift the partial result up one degree,
   // fold the x^8 overflow back in with the low polynomial bits, add a.
   function automatic logic [SYMBOL_W-1:0] field_mul(input logic [SYMBOL_W-1:0] a,
                                                     input logic [SYMBOL_W-1:0] b,
                                                     input logic [POLY_W-1:0] poly);
      logic [SYMBOL_W-1:0] prod;
      logic                carry;
      prod = '0;
      for (int i = SYMBOL_BITS - 1; i >= 0; i--) begin
         carry = prod[SYMBOL_BITS-1];
         prod  = prod << 1;
         if (carry) begin
            prod = prod ^ poly[SYMBOL_BITS-1:0];
         end
         if (b[i]) begin
            prod = prod ^ a;
         end
      end
      return prod;
   endfunction

   // Advance the shadow encoder by one accepted transaction and queue the
   // symbols it releases.
   task automatic encode_item(input req_item_type it);
      int         span;
      int         enabled;
      int         emitted;
      symbol_type s;
      span = (shadow_count > MAX_DATA) ? MAX_DATA : shadow_count;
      if (it.operation == OP_LOAD) begin
         coef_tab[it.column][it.coef_slot] = it.value;
      end else begin
         // Columns past data_count and zero data contribute nothing
         if (it.column < span && it.value != 0) begin
            for (int c = 0; c < MAX_COLUMNS; c++) begin
               if (shadow_select[c]) begin
                  parity_acc[c] ^= field_mul(coef_tab[c][it.column], it.value, shadow_poly);
               end
            end
         end
         if (it.last) begin
            enabled = 0;
            emitted = 0;
            for (int c = 0; c < MAX_COLUMNS; c++) begin
               if (shadow_select[c]) begin
                  enabled++;
               end
            end
            // Emit in ascending column order, flag the final one
            for (int c = 0; c < MAX_COLUMNS; c++) begin
               if (shadow_select[c]) begin
                  emitted++;
                  s.out_column = OUT_COLUMN_W'(c);
                  s.symbol     = parity_acc[c];
                  s.out_last   = (emitted == enabled);
                  pending_symbols.push_back(s);
               end
            end
            // Clear every accumulator, even with no column enabled
            for (int c = 0; c < MAX_COLUMNS; c++) begin
               parity_acc[c] = '0;
            end
         end
      end
   endtask

   task automatic flag_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   // Monitor: sample every handshake at the rising edge. Check symbols
   // against the oldest expectation, then feed accepted transactions and
   // register writes into the shadow encoder.
   always @(posedge clock) begin : monitor
      req_item_type seen;
      symbol_type   want;
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_symbols.size() == 0) begin
               flag_failure($sformatf("unexpected symbol: col %0d sym %02h last %0b",
                                      rsp_bus.out_column, rsp_bus.symbol, rsp_bus.out_last));
            end else begin
               want = pending_symbols.pop_front();
               if (rsp_bus.out_column !== want.out_column || rsp_bus.symbol !== want.symbol ||
                   rsp_bus.out_last !== want.out_last) begin
                  flag_failure($sformatf(
                     "symbol mismatch: expected col %0d sym %02h last %0b, got col %0d sym %02h last %0b",
                     want.out_column, want.symbol, want.out_last,
                     rsp_bus.out_column, rsp_bus.symbol, rsp_bus.out_last));
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.operation   = req_bus.operation;
            seen.column      = req_bus.column;
            seen.coef_slot   = req_bus.coef_slot;
            seen.value       = req_bus.value;
            seen.last        = req_bus.last;
            seen.drain_first = 1'b0;
            encode_item(seen);
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_DATA_COUNT: begin
                  shadow_count = csr_bus.data[DATA_COUNT_W-1:0];
               end
               CSR_COLUMN_SELECT: begin
                  shadow_select = csr_bus.data[SELECT_W-1:0];
               end
               CSR_FIELD_POLY: begin
                  shadow_poly = csr_bus.data[POLY_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Driver: on the falling edge, present the next queued transaction once the
   // current one is taken. Drop valid for random gaps; hold a drain-marked
   // transaction back until the block has handed out everything it owes.
   always @(negedge clock) begin : driver
      bit           gap;
      req_item_type nxt;
      if (!reset && (!req_bus.valid || req_taken)) begin
         gap = (flow_mode == FLOW_SRC_GAPS && $urandom_range(99) < 47) ||
               (flow_mode == FLOW_BOTH && $urandom_range(99) < 9);
         if (stim_q.size() != 0 && !gap &&
             !(stim_q[0].drain_first && pending_symbols.size() != 0)) begin
            nxt = stim_q.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.operation <= nxt.operation;
            req_bus.column    <= nxt.column;
            req_bus.coef_slot <= nxt.coef_slot;
            req_bus.value     <= nxt.value;
            req_bus.last      <= nxt.last;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver pacing: random stalls by flow mode, plus one long hold-off on
   // request so the emitter backs up and the input stalls.
   always @(negedge clock) begin : sink_pacer
      if (hold_go != hold_seen) begin
         hold_seen  = hold_go;
         stall_left = LONG_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (flow_mode == FLOW_SINK_STALLS) begin
         rsp_bus.ready <= ($urandom_range(99) >= 47);
      end else if (flow_mode == FLOW_BOTH) begin
         rsp_bus.ready <= ($urandom_range(99) >= 9);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   function automatic void push_item(input logic op, input int col, input int slot,
                                     input int val, input logic last, input bit drain = 1'b0);
      req_item_type it;
      it.operation   = op;
      it.column      = COLUMN_W'(col);
      it.coef_slot   = SLOT_W'(slot);
      it.value       = VALUE_W'(val);
      it.last        = last;
      it.drain_first = drain;
      stim_q.push_back(it);
   endfunction

   // Data bytes lean toward zero and the all-ones/one extremes
   function automatic int pick_datum();
      int r;
      r = $urandom_range(9);
      if (r == 0) begin
         return 0;
      end else if (r == 1) begin
         return 255;
      end else if (r == 2) begin
         return 1;
      end
      return $urandom_range(255);
   endfunction

   // One well-formed position: a byte for every counted data column, last on
   // the final one. With no column counted, send a short random burst instead.
   function automatic void queue_position(input int span);
      int n;
      n = (span == 0) ? $urandom_range(1, 3) : span;
      for (int d = 0; d < n; d++) begin
         push_item(OP_DATA, (span == 0) ? $urandom_range(15) : d, $urandom_range(15),
                   pick_datum(), d == n - 1);
      end
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] wdata);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= wdata;
      @(posedge clock);
      while (!csr_bus.ready) begin
         @(posedge clock);
      end
   endtask

   // Write all three registers back to back, release the channel, and
   // return on a rising edge so new stimulus never races the driver.
   task automatic program_regs(input int count, input int sel, input int poly);
      write_csr(CSR_DATA_COUNT, CSR_DATA_W'(count));
      write_csr(CSR_COLUMN_SELECT, CSR_DATA_W'(sel));
      write_csr(CSR_FIELD_POLY, CSR_DATA_W'(poly));
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until the driver is empty and every owed symbol is out, then give
   // the pipeline time to finish any transaction that releases nothing.
   task automatic settle();
      while (stim_q.size() != 0 || req_bus.valid || pending_symbols.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed positions with random content; the rest coefficient
   // reloads and stray data bytes, some of them marked last.
   task automatic random_phase(input flow_mode_type mode, input int count, input int sel,
                               input int poly, input int quota);
      int span;
      int r;
      program_regs(count, sel, poly);
      flow_mode = mode;
      span = (count > MAX_DATA) ? MAX_DATA : count;
      while (stim_q.size() < quota) begin
         r = $urandom_range(99);
         if (r < 70) begin
            queue_position(span);
         end else if (r < 85) begin
            push_item(OP_LOAD, $urandom_range(15), $urandom_range(15), pick_datum(),
                      1'($urandom_range(1)));
         end else begin
            push_item(OP_DATA, $urandom_range(15), $urandom_range(15), pick_datum(),
                      $urandom_range(9) == 0);
         end
      end
      settle();
   endtask

   initial begin : sequencer
      // Known values on every input from time zero
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_LOAD;
      req_bus.column    = '0;
      req_bus.coef_slot = '0;
      req_bus.value     = '0;
      req_bus.last      = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_DATA_COUNT;
      csr_bus.data      = '0;

      shadow_count  = DATA_COUNT_RESET;
      shadow_select = SELECT_RESET;
      shadow_poly   = POLY_RESET;
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         parity_acc[c] = '0;
         for (int d = 0; d < MAX_DATA; d++) begin
            coef_tab[c][d] = '0;
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole coefficient table first so no unwritten entry is
      // ever read. Reset registers leave no column enabled, so the last
      // byte that follows releases nothing but still clears the sums.
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         for (int d = 0; d < MAX_DATA; d++) begin
            push_item(OP_LOAD, c, d, ($urandom_range(99) < 15) ? 0 : $urandom_range(255),
                      1'($urandom_range(1)));
         end
      end
      push_item(OP_DATA, 0, 0, 8'h3c, 1'b1);
      settle();

      // Directed: extremes of column and value, zero datum, zero
      // coefficient, last on loads ignored
      program_regs(16, 16'hffff, POLY_RESET);
      push_item(OP_DATA, 0, 0, 8'hff, 1'b0);
      push_item(OP_DATA, 15, 15, 8'h01, 1'b0);
      push_item(OP_DATA, 7, 0, 8'h00, 1'b0);
      push_item(OP_DATA, 3, 0, 8'h80, 1'b1);
      push_item(OP_LOAD, 15, 15, 8'h00, 1'b1);
      push_item(OP_LOAD, 0, 0, 8'hff, 1'b0);
      push_item(OP_DATA, 15, 0, 8'hff, 1'b1);
      push_item(OP_DATA, 0, 0, 8'h00, 1'b1);
      push_item(OP_DATA, 0, 0, 8'hff, 1'b1);
      push_item(OP_DATA, 1, 0, 8'h55, 1'b0);
      settle();
      // Change the select mask in the middle of a position
      program_regs(16, 16'h00f0, POLY_RESET);
      push_item(OP_DATA, 2, 0, 8'haa, 1'b1);
      settle();
      // A byte of an uncounted column adds nothing but its last still emits
      program_regs(2, 16'h8001, POLY_RESET);
      push_item(OP_DATA, 9, 0, 8'h77, 1'b1);
      push_item(OP_DATA, 1, 0, 8'hfe, 1'b1);
      settle();
      // Zero data count: every symbol comes out zero
      program_regs(0, 16'hffff, 9'h187);
      push_item(OP_DATA, 0, 0, 8'hff, 1'b1);
      push_item(OP_DATA, 15, 0, 8'h5a, 1'b1);
      settle();

      // Back-pressure: hold the receiver off while full positions keep
      // coming, then hold the sender until the backlog has drained.
      program_regs(1, 16'hffff, POLY_RESET);
      flow_mode = FLOW_FREE;
      hold_go++;
      for (int i = 0; i < 6; i++) begin
         push_item(OP_DATA, 0, 0, pick_datum(), 1'b1);
      end
      push_item(OP_DATA, 0, 0, pick_datum(), 1'b1, 1'b1);
      push_item(OP_DATA, 0, 0, pick_datum(), 1'b1);
      settle();

      // Random phases over register extremes and every flow mode
      random_phase(FLOW_FREE, 16, 16'hffff, POLY_RESET, 6);
      random_phase(FLOW_SRC_GAPS, 1, 16'h0001, 9'h100, 6);
      random_phase(FLOW_SINK_STALLS, 31, 16'h8000, 9'h1ff, 6);
      random_phase(FLOW_BOTH, 0, 16'ha5a5, 9'h0ff, 4);
      random_phase(FLOW_SRC_GAPS, 17, 16'h0000, POLY_RESET, 4);
      random_phase(FLOW_FREE, 4, 16'h5a5a, 9'h000, 4);
      for (int k = 0; k < 4; k++) begin
         random_phase(flow_mode_type'(k % 4), $urandom_range(31), $urandom_range(65535),
                      $urandom_range(511), 4);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_symbols.size() != 0) begin
         flag_failure($sformatf("%0d symbols never arrived", pending_symbols.size()));
      end
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Hard stop far beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### gf256_matrix_parity_encoder.f
hw/rtl/gmpe_pkg.sv
hw/rtl/gmpe_ifs.sv
hw/rtl/gmpe_datapath.sv
hw/rtl/gmpe_emit.sv
hw/rtl/gf256_matrix_parity_encoder.sv
sim/tb.sv
